FILE: rtl/pbca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbca_pkg
// shared constants and types of the paged bitmap cluster allocator
// ----------------------------------------------------------------------------
package pbca_pkg;

  localparam int PAGE_BITS   = 2048;
  localparam int MAX_PAGES   = 32;
  localparam int WORD_W      = 64;
  localparam int TOTAL_BITS  = PAGE_BITS * MAX_PAGES;
  localparam int TOTAL_WORDS = TOTAL_BITS / WORD_W;

  localparam int BIT_W       = $clog2(WORD_W);
  localparam int PAGE_SH     = $clog2(PAGE_BITS);
  localparam int WORD_IDX_W  = PAGE_SH - BIT_W;
  localparam int PAGE_IDX_W  = $clog2(MAX_PAGES);
  localparam int PAGE_CNT_W  = PAGE_IDX_W + 1;
  localparam int ADDR_W      = PAGE_IDX_W + WORD_IDX_W;
  localparam int CLUSTER_W   = ADDR_W + BIT_W;
  localparam int CNT_W       = CLUSTER_W + 1;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_FORMAT = 2'd2,
    ACT_NONE   = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_FMT,
    ST_RESP
  } st_t;

endpackage

FILE: rtl/pbca_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbca_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module pbca_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/paged_bitmap_cluster_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_bitmap_cluster_allocator_unit
// free-cluster bitmap allocator over a paged usage bitmap held in one ram
// ----------------------------------------------------------------------------
// usage: requests come in on in_valid/in_stall with in_action (allocate,
// free, format, none) and in_cluster_index. every request gives exactly one
// result on out_valid/out_stall: out_cluster_number and out_found.
// the partition size is written on cfg_valid/cfg_ready; write it only while
// idle, the block itself does not enforce this. one request is worked at a
// time. the bitmap ram (1024 x 64) is read one word per cycle. an allocate
// reads w words, w at most pages*32, and shows its result before the next
// request is taken. free reads and rewrites one word, format sweeps every
// ram word, and an unused action answers without touching the ram.
// the bitmap is undefined after reset until the first format; reset sets
// the current page to 0 and the partition size to 65536.
// a finished result waits in the output register while out_stall is high;
// the next request is taken meanwhile and its result is held until the
// output register frees up.
// ----------------------------------------------------------------------------
module paged_bitmap_cluster_allocator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_action,
  input  logic [15:0]                        in_cluster_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [15:0]                        out_cluster_number,
  output logic                               out_found,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [16:0]                        cfg_partition_clusters
);

  localparam int AW  = pbca_pkg::ADDR_W;
  localparam int PW  = pbca_pkg::PAGE_IDX_W;
  localparam int WW  = pbca_pkg::WORD_IDX_W;
  localparam int BW  = pbca_pkg::BIT_W;
  localparam int PCW = pbca_pkg::PAGE_CNT_W;
  localparam int NW  = pbca_pkg::CNT_W;
  localparam int SH  = pbca_pkg::PAGE_SH;
  localparam int DW  = pbca_pkg::WORD_W;
  localparam int CW  = pbca_pkg::CLUSTER_W;

  pbca_pkg::st_t  state_r, state_nxt;
  pbca_pkg::act_t act_in;

  logic [NW-1:0]  eff_n_r, eff_n_nxt;
  logic [PW-1:0]  cur_page_r, cur_page_nxt;
  logic [PW-1:0]  start_page_r, start_page_nxt;
  logic [PW-1:0]  iss_page_r, iss_page_nxt;
  logic [WW-1:0]  iss_word_r, iss_word_nxt;
  logic [PCW-1:0] visited_r, visited_nxt;
  logic           iss_act_r, iss_act_nxt;
  logic           pipe_vld_r, pipe_vld_nxt;
  logic [PW-1:0]  pipe_page_r, pipe_page_nxt;
  logic [WW-1:0]  pipe_word_r, pipe_word_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic [AW-1:0]  fmt_addr_r, fmt_addr_nxt;
  logic [CW-1:0]  res_cluster_r, res_cluster_nxt;
  logic           res_found_r, res_found_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [CW-1:0]  out_cluster_r, out_cluster_nxt;
  logic           out_found_r, out_found_nxt;

  logic [NW-1:0]  pages_sum;
  logic [PCW-1:0] pages;
  logic [PCW-1:0] pages_m1;
  logic [PW-1:0]  last_page;
  logic [SH-1:0]  rem;
  logic [SH-1:0]  rem_m1;
  logic           partial;
  logic [WW-1:0]  iss_word_last;
  logic [PW-1:0]  iss_page_inc;
  logic [PW-1:0]  start_page;

  logic           lo_cond;
  logic           hi_cond;
  logic [DW-1:0]  scan_mask;
  logic [DW-1:0]  free_bits;
  logic           free_any;
  logic [BW-1:0]  free_pos;
  logic [DW-1:0]  fmt_mask;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [DW-1:0]  ram_wdata;
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [DW-1:0]  ram_rdata;

  pbca_ram #(
    .WIDTH (DW),
    .DEPTH (pbca_pkg::TOTAL_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // partition geometry
  assign pages_sum = eff_n_r + NW'(pbca_pkg::PAGE_BITS - 1);
  assign pages     = pages_sum[NW-1:SH];
  assign pages_m1  = pages - PCW'(1);
  assign last_page = pages_m1[PW-1:0];
  assign rem       = eff_n_r[SH-1:0];
  assign rem_m1    = rem - SH'(1);
  assign partial   = (rem != '0);
  assign start_page = ({1'b0, cur_page_r} < pages) ? cur_page_r : '0;

  assign iss_word_last = (iss_page_r == last_page && partial) ? rem_m1[SH-1:BW] : '1;
  assign iss_page_inc  = (iss_page_r == last_page) ? '0 : iss_page_r + PW'(1);

  // usable bits of the word in the data stage
  assign lo_cond = (pipe_page_r == '0) && (pipe_word_r == '0);
  assign hi_cond = (pipe_page_r == last_page) && partial && (pipe_word_r == rem_m1[SH-1:BW]);

  always_comb begin
    for (int b = 0; b < DW; b++) begin
      scan_mask[b] = (!lo_cond || (PCW'(b) >= pages)) &&
                     (!hi_cond || (BW'(b) <= rem_m1[BW-1:0]));
      fmt_mask[b]  = (PCW'(b) < pages);
    end
  end

  assign free_bits = ~ram_rdata & scan_mask;
  assign free_any  = |free_bits;

  always_comb begin
    free_pos = '0;
    for (int b = DW - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        free_pos = BW'(b);
      end
    end
  end

  assign act_in = pbca_pkg::act_t'(in_action);

  always_comb begin
    eff_n_nxt = eff_n_r;
    if (cfg_valid && cfg_ready) begin
      priority if (cfg_partition_clusters == '0) begin
        eff_n_nxt = NW'(1);
      end else if (cfg_partition_clusters > NW'(pbca_pkg::TOTAL_BITS)) begin
        eff_n_nxt = NW'(pbca_pkg::TOTAL_BITS);
      end else begin
        eff_n_nxt = cfg_partition_clusters;
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cur_page_nxt    = cur_page_r;
    start_page_nxt  = start_page_r;
    iss_page_nxt    = iss_page_r;
    iss_word_nxt    = iss_word_r;
    visited_nxt     = visited_r;
    iss_act_nxt     = iss_act_r;
    pipe_vld_nxt    = 1'b0;
    pipe_page_nxt   = pipe_page_r;
    pipe_word_nxt   = pipe_word_r;
    idx_nxt         = idx_r;
    fmt_addr_nxt    = fmt_addr_r;
    res_cluster_nxt = res_cluster_r;
    res_found_nxt   = res_found_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_cluster_nxt = out_cluster_r;
    out_found_nxt   = out_found_r;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = '0;

    unique case (state_r)
      pbca_pkg::ST_IDLE: begin
        if (in_valid) begin
          res_cluster_nxt = '0;
          res_found_nxt   = 1'b0;
          idx_nxt         = in_cluster_index;
          unique case (act_in)
            pbca_pkg::ACT_ALLOC: begin
              start_page_nxt = start_page;
              iss_page_nxt   = start_page;
              iss_word_nxt   = '0;
              visited_nxt    = '0;
              iss_act_nxt    = 1'b1;
              state_nxt      = pbca_pkg::ST_SCAN;
            end
            pbca_pkg::ACT_FREE: begin
              if ({1'b0, in_cluster_index} < eff_n_r) begin
                cur_page_nxt = in_cluster_index[CW-1:SH];
                state_nxt    = pbca_pkg::ST_FREE_RD;
              end else begin
                state_nxt = pbca_pkg::ST_RESP;
              end
            end
            pbca_pkg::ACT_FORMAT: begin
              fmt_addr_nxt = '0;
              state_nxt    = pbca_pkg::ST_FMT;
            end
            default: begin
              state_nxt = pbca_pkg::ST_RESP;
            end
          endcase
        end
      end

      pbca_pkg::ST_SCAN: begin
        // issue side: one word read per cycle
        if (iss_act_r) begin
          ram_re        = 1'b1;
          ram_raddr     = {iss_page_r, iss_word_r};
          pipe_vld_nxt  = 1'b1;
          pipe_page_nxt = iss_page_r;
          pipe_word_nxt = iss_word_r;
          if (iss_word_r == iss_word_last) begin
            iss_word_nxt = '0;
            iss_page_nxt = iss_page_inc;
            visited_nxt  = visited_r + PCW'(1);
            if (visited_r == pages_m1) begin
              iss_act_nxt = 1'b0;
            end
          end else begin
            iss_word_nxt = iss_word_r + WW'(1);
          end
        end
        // data side: take lowest free bit
        if (pipe_vld_r) begin
          priority if (free_any) begin
            ram_we          = 1'b1;
            ram_waddr       = {pipe_page_r, pipe_word_r};
            ram_wdata       = ram_rdata | (DW'(1) << free_pos);
            res_cluster_nxt = {pipe_page_r, pipe_word_r, free_pos};
            res_found_nxt   = 1'b1;
            cur_page_nxt    = pipe_page_r;
            iss_act_nxt     = 1'b0;
            pipe_vld_nxt    = 1'b0;
            state_nxt       = pbca_pkg::ST_RESP;
          end else if (!iss_act_r) begin
            cur_page_nxt = start_page_r;
            state_nxt    = pbca_pkg::ST_RESP;
          end else begin
            state_nxt = pbca_pkg::ST_SCAN;
          end
        end
      end

      pbca_pkg::ST_FREE_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r[CW-1:BW];
        state_nxt = pbca_pkg::ST_FREE_WR;
      end

      pbca_pkg::ST_FREE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[CW-1:BW];
        ram_wdata = ram_rdata & ~(DW'(1) << idx_r[BW-1:0]);
        state_nxt = pbca_pkg::ST_RESP;
      end

      pbca_pkg::ST_FMT: begin
        ram_we       = 1'b1;
        ram_waddr    = fmt_addr_r;
        ram_wdata    = (fmt_addr_r == '0) ? fmt_mask : '0;
        fmt_addr_nxt = fmt_addr_r + AW'(1);
        if (fmt_addr_r == '1) begin
          cur_page_nxt = '0;
          state_nxt    = pbca_pkg::ST_RESP;
        end
      end

      pbca_pkg::ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_cluster_nxt = res_cluster_r;
          out_found_nxt   = res_found_r;
          state_nxt       = pbca_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pbca_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbca_pkg::ST_IDLE;
      eff_n_r     <= NW'(pbca_pkg::TOTAL_BITS);
      cur_page_r  <= '0;
      iss_act_r   <= 1'b0;
      pipe_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      eff_n_r     <= eff_n_nxt;
      cur_page_r  <= cur_page_nxt;
      iss_act_r   <= iss_act_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_page_r  <= start_page_nxt;
    iss_page_r    <= iss_page_nxt;
    iss_word_r    <= iss_word_nxt;
    visited_r     <= visited_nxt;
    pipe_page_r   <= pipe_page_nxt;
    pipe_word_r   <= pipe_word_nxt;
    idx_r         <= idx_nxt;
    fmt_addr_r    <= fmt_addr_nxt;
    res_cluster_r <= res_cluster_nxt;
    res_found_r   <= res_found_nxt;
    out_cluster_r <= out_cluster_nxt;
    out_found_r   <= out_found_nxt;
  end

  assign in_stall           = (state_r != pbca_pkg::ST_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_cluster_number = out_cluster_r;
  assign out_found          = out_found_r;

  // reserved clusters are never handed out
  a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_cluster_number != '0)
    else $error("allocated a reserved cluster");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_cluster_number == '0)
    else $error("nonzero cluster without found");

  // allocation stays inside the partition
  a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && state_r == pbca_pkg::ST_SCAN |-> {1'b0, ram_waddr, free_pos} < eff_n_r)
    else $error("allocation beyond partition size");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r != pbca_pkg::ST_IDLE && state_r != pbca_pkg::ST_RESP)
    else $error("bitmap written outside of a request");

  a_fmt_page: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pbca_pkg::ST_FMT && fmt_addr_r == '1 |=> cur_page_r == '0)
    else $error("format did not reset current page");

endmodule
